[src/two_level_page_table_map_query_top_macros.svh]
// ----------------------------------------------------------------------------
// two_level_page_table_map_query_top_macros
// assertion macros used by the page table datapath
// ----------------------------------------------------------------------------
`ifndef TWO_LEVEL_PAGE_TABLE_MAP_QUERY_TOP_MACROS_SVH
`define TWO_LEVEL_PAGE_TABLE_MAP_QUERY_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define TLPT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define TLPT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/tlpt_pkg.sv]
// ----------------------------------------------------------------------------
// tlpt_pkg
// widths, codes and control types of the two-level page table block
// ----------------------------------------------------------------------------
package tlpt_pkg;

    localparam int TABLE_SLOTS_DEF   = 16;
    localparam int ENTRIES_PER_TABLE = 1024;
    localparam int IDX_W             = $clog2(ENTRIES_PER_TABLE);
    localparam int DIR_DEPTH         = 1024;
    localparam int VPN_W             = 20;
    localparam int FRAME_W           = 20;
    localparam int FLAGS_W           = 6;
    localparam int ENTRY_W           = FRAME_W + FLAGS_W;
    localparam int STATUS_W          = 2;
    localparam int FLAG_PRESENT_BIT  = 0;

    localparam logic CMD_MAP   = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [STATUS_W-1:0] ST_MAPPED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_KEPT   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOSLOT = 2'd2;
    localparam logic [STATUS_W-1:0] ST_QUERY  = 2'd3;

    typedef struct packed {
        logic                latch;
        logic                dir_rd;
        logic                dir_clr_wr;
        logic                dir_alloc_wr;
        logic                slot_ld;
        logic                next_inc;
        logic                clr_inc;
        logic                tbl_rd;
        logic                tbl_clr_wr;
        logic                tbl_wr;
        logic                res_ld;
        logic                res_from_tbl;
        logic [STATUS_W-1:0] res_status;
        logic                out_ld;
    } t_dp_cmd;

    typedef struct packed {
        logic is_query;
        logic dir_present;
        logic slots_full;
        logic frame_nz;
        logic clr_last;
        logic out_busy;
    } t_dp_sts;

endpackage

[src/tlpt_ctrl.sv]
// ----------------------------------------------------------------------------
// tlpt_ctrl
// sequencer for directory lookup, table allocation, clearing and result beats
// ----------------------------------------------------------------------------
module tlpt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  tlpt_pkg::t_dp_sts i_sts,
    output tlpt_pkg::t_dp_cmd o_ctl
);
    import tlpt_pkg::*;

    localparam logic [2:0] S_DCLR = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_DIR  = 3'd2;
    localparam logic [2:0] S_TCHK = 3'd3;
    localparam logic [2:0] S_TCLR = 3'd4;
    localparam logic [2:0] S_TWR  = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_DCLR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_ctl      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_DCLR: begin
                o_ctl.dir_clr_wr = 1'b1;
                o_ctl.clr_inc    = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ctl.latch  = 1'b1;
                    o_ctl.dir_rd = 1'b1;
                    n_state      = S_DIR;
                end
            end
            S_DIR: begin
                o_ctl.slot_ld = 1'b1;
                if (i_sts.dir_present) begin
                    o_ctl.tbl_rd = 1'b1;
                    n_state      = S_TCHK;
                end else if (i_sts.is_query) begin
                    o_ctl.res_ld     = 1'b1;
                    o_ctl.res_status = ST_QUERY;
                    n_state          = S_DONE;
                end else if (i_sts.slots_full) begin
                    o_ctl.res_ld     = 1'b1;
                    o_ctl.res_status = ST_NOSLOT;
                    n_state          = S_DONE;
                end else begin
                    o_ctl.dir_alloc_wr = 1'b1;
                    o_ctl.next_inc     = 1'b1;
                    n_state            = S_TCLR;
                end
            end
            S_TCHK: begin
                o_ctl.res_ld = 1'b1;
                n_state      = S_DONE;
                if (i_sts.is_query) begin
                    o_ctl.res_from_tbl = 1'b1;
                    o_ctl.res_status   = ST_QUERY;
                end else if (i_sts.frame_nz) begin
                    o_ctl.res_status = ST_KEPT;
                end else begin
                    o_ctl.tbl_wr     = 1'b1;
                    o_ctl.res_status = ST_MAPPED;
                end
            end
            S_TCLR: begin
                o_ctl.tbl_clr_wr = 1'b1;
                o_ctl.clr_inc    = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_TWR;
                end
            end
            S_TWR: begin
                o_ctl.tbl_wr     = 1'b1;
                o_ctl.res_ld     = 1'b1;
                o_ctl.res_status = ST_MAPPED;
                n_state          = S_DONE;
            end
            S_DONE: begin
                if (!i_sts.out_busy) begin
                    o_ctl.out_ld = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_DCLR;
            end
        endcase
    end

endmodule

[src/tlpt_dp.sv]
// ----------------------------------------------------------------------------
// tlpt_dp
// directory and table memories, slot counter, sweep counter, result register
// ----------------------------------------------------------------------------
`include "two_level_page_table_map_query_top_macros.svh"

module tlpt_dp #(
    parameter int TABLE_SLOTS = tlpt_pkg::TABLE_SLOTS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  tlpt_pkg::t_dp_cmd               i_ctl,
    output tlpt_pkg::t_dp_sts               o_sts,
    input  logic                            i_cmd,
    input  logic [tlpt_pkg::VPN_W-1:0]      i_virt_page,
    input  logic [tlpt_pkg::FRAME_W-1:0]    i_phys_frame,
    input  logic [tlpt_pkg::FLAGS_W-1:0]    i_page_flags,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [tlpt_pkg::STATUS_W-1:0]   o_status,
    output logic                            o_page_present
);
    import tlpt_pkg::*;

    localparam int SLOT_W    = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CNT_W     = $clog2(TABLE_SLOTS + 1);
    localparam int DIR_W     = SLOT_W + 1;
    localparam int TBL_DEPTH = TABLE_SLOTS * ENTRIES_PER_TABLE;
    localparam int TBL_AW    = $clog2(TBL_DEPTH);
    localparam int FULL_AW   = SLOT_W + IDX_W;

    logic                r_cmd;
    logic [VPN_W-1:0]    r_vpn;
    logic [FRAME_W-1:0]  r_frame;
    logic [FLAGS_W-1:0]  r_flags;
    logic [DIR_W-1:0]    r_dir_rd;
    logic [SLOT_W-1:0]   r_slot;
    logic [CNT_W-1:0]    r_next;
    logic [IDX_W-1:0]    r_clr_cnt;
    logic [ENTRY_W-1:0]  r_tbl_rd;
    logic [STATUS_W-1:0] r_res_status;
    logic                r_res_present;
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic                r_out_present;

    logic [DIR_W-1:0]    dir_mem [DIR_DEPTH];
    logic [ENTRY_W-1:0]  tbl_mem [TBL_DEPTH];

    logic                w_dir_present;
    logic [SLOT_W-1:0]   w_dir_slot;
    logic [FULL_AW-1:0]  w_rd_full;
    logic [FULL_AW-1:0]  w_wr_full;
    logic [TBL_AW-1:0]   w_rd_addr;
    logic [TBL_AW-1:0]   w_wr_addr;
    logic [ENTRY_W-1:0]  w_wr_data;

    assign w_dir_present = r_dir_rd[DIR_W-1];
    assign w_dir_slot    = r_dir_rd[SLOT_W-1:0];
    assign w_rd_full     = {w_dir_slot, r_vpn[IDX_W-1:0]};
    assign w_wr_full     = {r_slot, i_ctl.tbl_clr_wr ? r_clr_cnt : r_vpn[IDX_W-1:0]};
    assign w_rd_addr     = w_rd_full[TBL_AW-1:0];
    assign w_wr_addr     = w_wr_full[TBL_AW-1:0];
    assign w_wr_data     = i_ctl.tbl_clr_wr ? '0 : {r_frame, r_flags};

    // captured command beat
    always_ff @(posedge i_clk) begin
        if (i_ctl.latch) begin
            r_cmd   <= i_cmd;
            r_vpn   <= i_virt_page;
            r_frame <= i_phys_frame;
            r_flags <= i_page_flags;
        end
    end

    // directory memory
    always_ff @(posedge i_clk) begin
        if (i_ctl.dir_clr_wr) begin
            dir_mem[r_clr_cnt] <= '0;
        end else if (i_ctl.dir_alloc_wr) begin
            dir_mem[r_vpn[VPN_W-1 -: IDX_W]] <= {1'b1, r_next[SLOT_W-1:0]};
        end
        if (i_ctl.dir_rd) begin
            r_dir_rd <= dir_mem[i_virt_page[VPN_W-1 -: IDX_W]];
        end
    end

    // table memory
    always_ff @(posedge i_clk) begin
        if (i_ctl.tbl_clr_wr || i_ctl.tbl_wr) begin
            tbl_mem[w_wr_addr] <= w_wr_data;
        end
        if (i_ctl.tbl_rd) begin
            r_tbl_rd <= tbl_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.slot_ld) begin
            r_slot <= w_dir_present ? w_dir_slot : r_next[SLOT_W-1:0];
        end
        if (i_ctl.res_ld) begin
            r_res_status  <= i_ctl.res_status;
            r_res_present <= i_ctl.res_from_tbl & r_tbl_rd[FLAG_PRESENT_BIT];
        end
        if (i_ctl.out_ld) begin
            r_out_status  <= r_res_status;
            r_out_present <= r_res_present;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next      <= '0;
            r_clr_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_ctl.next_inc) begin
                r_next <= r_next + CNT_W'(1);
            end
            if (i_ctl.clr_inc) begin
                r_clr_cnt <= r_clr_cnt + IDX_W'(1);
            end
            if (i_ctl.out_ld) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.is_query    = (r_cmd == CMD_QUERY);
    assign o_sts.dir_present = w_dir_present;
    assign o_sts.slots_full  = (r_next == CNT_W'(TABLE_SLOTS));
    assign o_sts.frame_nz    = |r_tbl_rd[ENTRY_W-1:FLAGS_W];
    assign o_sts.clr_last    = &r_clr_cnt;
    assign o_sts.out_busy    = r_out_valid & ~i_out_ready;

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_page_present = r_out_present;

    `TLPT_ASSERT_IMP(a_alloc_has_slot, i_ctl.dir_alloc_wr, !o_sts.slots_full, "alloc with no slot")
    `TLPT_ASSERT_IMP(a_next_bound, 1'b1, r_next <= CNT_W'(TABLE_SLOTS), "slot count overran")
    `TLPT_ASSERT_IMP(a_wr_excl, i_ctl.tbl_wr, !i_ctl.tbl_clr_wr, "table write during clear")
    `TLPT_ASSERT_IMP(a_out_free, i_ctl.out_ld, !o_sts.out_busy, "result beat overwritten")
    `TLPT_ASSERT_NXT(a_alloc_clear, i_ctl.dir_alloc_wr, r_clr_cnt == '0, "table clear misaligned")

endmodule

[src/two_level_page_table_map_query_top.sv]
// the input beat is captured with the directory read, then the table is read and
// the result loaded; a query with no directory entry or a map with no slot left
// skips the table read; a map that allocates a table first clears its 1024-entry
// table, one entry per cycle; a new beat is taken once the last result is loaded.
// reset: synchronous active low; the directory is then swept one entry per cycle,
// with the input not ready.
// ----------------------------------------------------------------------------
// two_level_page_table_map_query_top
// two-level page table with map and query commands
// ----------------------------------------------------------------------------
module two_level_page_table_map_query_top #(
    parameter int TABLE_SLOTS = tlpt_pkg::TABLE_SLOTS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_cmd,
    input  logic [tlpt_pkg::VPN_W-1:0]      i_virt_page,
    input  logic [tlpt_pkg::FRAME_W-1:0]    i_phys_frame,
    input  logic [tlpt_pkg::FLAGS_W-1:0]    i_page_flags,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [tlpt_pkg::STATUS_W-1:0]   o_status,
    output logic                            o_page_present
);
    import tlpt_pkg::*;

    t_dp_cmd w_ctl;
    t_dp_sts w_sts;

    tlpt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_ctl      (w_ctl)
    );

    tlpt_dp #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (w_ctl),
        .o_sts          (w_sts),
        .i_cmd          (i_cmd),
        .i_virt_page    (i_virt_page),
        .i_phys_frame   (i_phys_frame),
        .i_page_flags   (i_page_flags),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_page_present (o_page_present)
    );

endmodule
